// File: sv/wma_pkg.sv
// Shared types and constants for the windowed moving average block.
// No dependencies; compiled first.
`default_nettype none

package wma_pkg;

  // Width of the window length register as seen on the configuration port
  localparam int CFG_BITS = 7;

  // Fraction bits added to the average
  localparam int FRAC_BITS = 8;

  // Entries in the queue between the window front end and the divider
  localparam int QUEUE_DEPTH = 2;

  // Control tag that travels with each queued window sum
  typedef struct packed {
    logic short_vec;  // vector ended before the window filled
    logic last;       // result closes the vector
  } wma_tag_t;

  localparam int TAG_BITS = $bits(wma_tag_t);

endpackage

`default_nettype wire

// File: sv/wma_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on nothing; compiled after wma_pkg.
`default_nettype none

interface wma_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface wma_out_if #(
  parameter int AVG_BITS = 24
);
  logic                       valid;
  logic                       ready;
  logic signed [AVG_BITS-1:0] average;
  logic                       status;
  logic                       end_of_vector;

  modport source (output valid, output average, output status, output end_of_vector,
                  input ready);
  modport sink   (input valid, input average, input status, input end_of_vector,
                  output ready);
endinterface

`default_nettype wire

// File: sv/wma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-first when both ports hit the same address. No dependencies.
`default_nettype none

module wma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output      logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: sv/wma_front.sv
// Front end: accepts samples, keeps the sample ring, fill count and running sum,
// and queues one window sum per result. Depends on wma_pkg, wma_if, wma_ram.
`default_nettype none

module wma_front
  import wma_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int W_BITS      = 7,
  parameter int SUM_BITS    = 22,
  parameter int QC_BITS     = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  wma_in_if.sink                          in_ch,
  input  wire logic [W_BITS-1:0]          eff_w,
  input  wire logic                       cfg_clear,
  input  wire logic [QC_BITS-1:0]         q_count,
  output      logic                       push,
  output      logic signed [SUM_BITS-1:0] push_sum,
  output      wma_tag_t                   push_tag
);

  localparam int A_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int D_BITS = W_BITS + 1;

  logic [A_BITS-1:0]             ptr;
  logic [A_BITS-1:0]             ptr_next;
  logic [W_BITS-1:0]             fill;
  logic [W_BITS-1:0]             fill_after;
  logic                          full_before;
  logic                          has_avg;
  logic [D_BITS-1:0]             old_diff;
  logic [A_BITS-1:0]             old_addr;
  logic                          accept;

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic                          s1_sub;
  logic                          s1_avg;
  logic                          s1_last;
  logic [SAMPLE_BITS-1:0]        old_raw;
  logic signed [SUM_BITS-1:0]    sum;
  logic signed [SUM_BITS-1:0]    sum_next;
  logic signed [SUM_BITS-1:0]    old_ext;
  logic [QC_BITS:0]              pending;

  // Leave room in the queue for the item already in the sum stage
  assign pending     = (QC_BITS + 1)'(q_count) + (QC_BITS + 1)'(s1_valid);
  assign in_ch.ready = (pending < (QC_BITS + 1)'(QUEUE_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  assign full_before = (fill >= eff_w);
  assign fill_after  = full_before ? fill : fill + W_BITS'(1);
  assign has_avg     = (fill_after >= eff_w);

  assign ptr_next = (ptr == A_BITS'(WINDOW_MAX - 1)) ? '0 : ptr + A_BITS'(1);

  // Oldest sample of the window, wrapped around the ring
  assign old_diff = D_BITS'(ptr) - D_BITS'(eff_w);
  assign old_addr = old_diff[D_BITS-1] ? A_BITS'(old_diff + D_BITS'(WINDOW_MAX))
                                       : A_BITS'(old_diff);

  wma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (ptr),
    .wr_data (in_ch.sample),
    .rd_addr (old_addr),
    .rd_data (old_raw)
  );

  assign old_ext  = SUM_BITS'($signed(old_raw));
  assign sum_next = sum - (s1_sub ? old_ext : '0) + SUM_BITS'(s1_sample);

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      ptr      <= '0;
      fill     <= '0;
      s1_valid <= 1'b0;
      sum      <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        ptr  <= in_ch.last_sample ? '0 : ptr_next;
        fill <= in_ch.last_sample ? '0 : fill_after;
      end
      if (s1_valid) begin
        sum <= s1_last ? '0 : sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= in_ch.sample;
      s1_sub    <= full_before;
      s1_avg    <= has_avg;
      s1_last   <= in_ch.last_sample;
    end
  end

  assign push               = s1_valid && (s1_avg || s1_last);
  assign push_sum           = sum_next;
  assign push_tag.short_vec = !s1_avg;
  assign push_tag.last      = s1_last;

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= eff_w)
    else $error("fill count exceeds window length");

  a_sum_clears: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last |=> sum == '0)
    else $error("running sum not cleared after last sample");

endmodule

`default_nettype wire

// File: sv/wma_queue.sv
// Small register FIFO between the window front end and the divider.
// Depends on nothing but its parameters.
`default_nettype none

module wma_queue #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2,
  localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire logic [WIDTH-1:0]    push_data,
  input  wire logic                pop,
  output      logic [WIDTH-1:0]    pop_data,
  output      logic                empty,
  output      logic [CNT_BITS-1:0] count
);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [IDX_BITS-1:0] wr_idx;
  logic [IDX_BITS-1:0] rd_idx;

  function automatic logic [IDX_BITS-1:0] wrap_inc(input logic [IDX_BITS-1:0] idx);
    return (idx == IDX_BITS'(DEPTH - 1)) ? '0 : idx + IDX_BITS'(1);
  endfunction

  assign empty    = (count == '0);
  assign pop_data = slots[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= wrap_inc(wr_idx);
      end
      if (pop) begin
        rd_idx <= wrap_inc(rd_idx);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_BITS'(1);
        2'b01:   count <= count - CNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CNT_BITS'(DEPTH))
    else $error("push into full queue");

endmodule

`default_nettype wire

// File: sv/wma_back.sv
// Back end: bit-serial divider that turns a window sum into sum*256/window,
// truncated toward zero, plus the output register. Depends on wma_pkg, wma_if.
`default_nettype none

module wma_back
  import wma_pkg::*;
#(
  parameter int W_BITS   = 7,
  parameter int SUM_BITS = 22,
  parameter int AVG_BITS = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [W_BITS-1:0]          eff_w,
  input  wire logic                       q_empty,
  input  wire logic signed [SUM_BITS-1:0] q_sum,
  input  wire wma_tag_t                   q_tag,
  output      logic                       q_pop,
  wma_out_if.source                       out_ch
);

  localparam int DW       = SUM_BITS + FRAC_BITS;
  localparam int CNT_BITS = $clog2(DW + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                      state;
  logic [DW-1:0]               dq;
  logic [W_BITS-1:0]           rem;
  logic [CNT_BITS-1:0]         cnt;
  logic                        neg;
  logic                        res_short;
  logic                        res_last;

  logic [SUM_BITS-1:0]         mag;
  logic [W_BITS:0]             shifted;
  logic [W_BITS:0]             diff;
  logic                        q_bit;
  logic [AVG_BITS-1:0]         quot_lo;
  logic [AVG_BITS-1:0]         avg_res;
  logic                        out_free;

  logic                        out_valid;
  logic signed [AVG_BITS-1:0]  out_avg;
  logic                        out_status;
  logic                        out_eov;

  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign mag   = q_sum[SUM_BITS-1] ? SUM_BITS'(-q_sum) : SUM_BITS'(q_sum);

  // One restoring step per cycle
  assign shifted = {rem, dq[DW-1]};
  assign diff    = shifted - {1'b0, eff_w};
  assign q_bit   = !diff[W_BITS];

  assign quot_lo  = dq[AVG_BITS-1:0];
  assign avg_res  = res_short ? '0 : (neg ? -quot_lo : quot_lo);
  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= q_tag.short_vec ? ST_DONE : ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == CNT_BITS'(1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold the finished quotient until the output slot frees up
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dq        <= {mag, FRAC_BITS'(0)};
      rem       <= '0;
      cnt       <= CNT_BITS'(DW);
      neg       <= q_sum[SUM_BITS-1];
      res_short <= q_tag.short_vec;
      res_last  <= q_tag.last;
    end else if (state == ST_DIV) begin
      dq  <= {dq[DW-2:0], q_bit};
      rem <= q_bit ? diff[W_BITS-1:0] : shifted[W_BITS-1:0];
      cnt <= cnt - CNT_BITS'(1);
    end
    if (state == ST_DONE && out_free) begin
      out_avg    <= avg_res;
      out_status <= res_short;
      out_eov    <= res_last;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.average       = out_avg;
  assign out_ch.status        = out_status;
  assign out_ch.end_of_vector = out_eov;

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |-> out_avg == '0 && out_eov)
    else $error("short-vector status without zero average and end of vector");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |=> state == ST_DIV || state == ST_DONE)
    else $error("divider left before finishing");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_valid && !out_ch.ready |=> state == ST_DONE)
    else $error("finished result dropped while output stalled");

endmodule

`default_nettype wire

// File: sv/windowed_moving_average_top.sv
// Moving average over a stream of signed samples: window register, front end,
// queue and divider. Depends on wma_pkg, wma_if, wma_front, wma_queue, wma_back.
//
// Usage:
//   in_ch  (valid/ready): one sample per transaction, last_sample closes a vector.
//   out_ch (valid/ready): average (8 fraction bits, truncated toward zero),
//     status (1 = vector ended before the window filled) and end_of_vector.
//   cfg_we/cfg_wdata: window length; 0 acts as 1, values above WINDOW_MAX
//     saturate. A write also restarts the vector in progress. Write only while
//     idle.
// Flow: a sample that completes a window passes the sum stage and the queue;
//   the divider then takes its SUM_BITS-bit window sum bit-serially, where
//   SUM_BITS = SAMPLE_BITS + log2(WINDOW_MAX).
// Throughput: samples that give no result enter at one per cycle while the
//   queue has room. Each average occupies the bit-serial divider until its
//   quotient is handed over, so with a full window samples enter only as fast
//   as the divider finishes them; a two-entry queue sits ahead of the divider.
// Reset: window length returns to 1 and all window state clears.
// Receiver stall: the result holds in the output register, the divider holds
//   its next result, and input ready drops once the queue fills.
`default_nettype none

module windowed_moving_average_top
  import wma_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  wma_in_if.sink                   in_ch,
  wma_out_if.source                out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CFG_BITS-1:0] cfg_wdata
);

  localparam int W_BITS   = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS = SAMPLE_BITS + ((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 0);
  localparam int AVG_BITS = SAMPLE_BITS + FRAC_BITS;
  localparam int CMP_BITS = (CFG_BITS > W_BITS) ? CFG_BITS : W_BITS;
  localparam int QC_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int Q_WIDTH  = SUM_BITS + TAG_BITS;

  logic [W_BITS-1:0]          eff_w;
  logic [CMP_BITS-1:0]        cfg_ext;

  logic                       push;
  logic signed [SUM_BITS-1:0] push_sum;
  wma_tag_t                   push_tag;
  logic                       q_pop;
  logic [Q_WIDTH-1:0]         q_data;
  logic                       q_empty;
  logic [QC_BITS-1:0]         q_count;
  logic signed [SUM_BITS-1:0] q_sum;
  wma_tag_t                   q_tag;

  assign cfg_ext = CMP_BITS'(cfg_wdata);

  // Store the effective window length so both ends see a clamped value
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= W_BITS'(1);
    end else if (cfg_we) begin
      if (cfg_ext == '0) begin
        eff_w <= W_BITS'(1);
      end else if (cfg_ext > CMP_BITS'(WINDOW_MAX)) begin
        eff_w <= W_BITS'(WINDOW_MAX);
      end else begin
        eff_w <= W_BITS'(cfg_ext);
      end
    end
  end

  wma_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .W_BITS      (W_BITS),
    .SUM_BITS    (SUM_BITS),
    .QC_BITS     (QC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .eff_w     (eff_w),
    .cfg_clear (cfg_we),
    .q_count   (q_count),
    .push      (push),
    .push_sum  (push_sum),
    .push_tag  (push_tag)
  );

  wma_queue #(
    .WIDTH (Q_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_tag, push_sum}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  assign q_sum = q_data[SUM_BITS-1:0];
  assign q_tag = q_data[Q_WIDTH-1:SUM_BITS];

  wma_back #(
    .W_BITS   (W_BITS),
    .SUM_BITS (SUM_BITS),
    .AVG_BITS (AVG_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .eff_w   (eff_w),
    .q_empty (q_empty),
    .q_sum   (q_sum),
    .q_tag   (q_tag),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// File: tb/sv/wma_average_checker.sv
`timescale 1ns / 100ps
// Checker for the windowed moving average block: watches both channels and the
// window register port, predicts each result and compares it. Depends on nothing.

module wma_average_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic signed [15:0] in_sample,
  input  wire logic               in_last,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [23:0] out_average,
  input  wire logic               out_status,
  input  wire logic               out_eov,
  input  wire logic               cfg_we,
  input  wire logic [6:0]         cfg_wdata,
  output int                      mismatches,
  output int                      outstanding
);

  localparam int RING_DEPTH = 64;
  localparam int REPORT_MAX = 10;

  typedef enum logic {AVG_VALID = 1'b0, AVG_TOO_FEW = 1'b1} avg_status_e;

  typedef struct packed {
    logic signed [23:0] average;
    logic               status;
    logic               end_of_vector;
  } avg_result_t;

  logic signed [15:0] sample_hist [RING_DEPTH];
  logic signed [21:0] window_sum;
  int unsigned        held_count;
  logic [5:0]         wr_ptr;
  logic [6:0]         window_reg;
  avg_result_t        expected_avgs [$];

  function automatic int unsigned active_window(input logic [6:0] reg_val);
    if (reg_val == 7'd0) return 1;
    if (reg_val > 7'(RING_DEPTH)) return RING_DEPTH;
    return 32'(reg_val);
  endfunction

  // append a predicted result behind the ones still awaited
  function automatic void note_expected(input avg_result_t res);
    expected_avgs = {expected_avgs, res};
  endfunction

  always @(posedge clk) begin : predict_and_compare
    avg_result_t got;
    avg_result_t want;
    int unsigned win;
    logic [5:0]  oldest;
    longint      scaled;
    if (rst) begin
      window_reg = 7'd1;
      window_sum = '0;
      held_count = 0;
      wr_ptr     = '0;
      mismatches = 0;
      expected_avgs.delete();
    end else begin
      // compare first: a result never belongs to a sample taken in the same cycle
      if (out_valid && out_ready) begin
        got = '{out_average, out_status, out_eov};
        if (expected_avgs.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: average %0d status %0b end_of_vector %0b",
                     got.average, got.status, got.end_of_vector);
        end else begin
          want = expected_avgs.pop_front();
          if (got.average !== want.average || got.status !== want.status ||
              got.end_of_vector !== want.end_of_vector) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("result differs: average exp %0d got %0d, status exp %0b got %0b, %s",
                       want.average, got.average, want.status, got.status,
                       $sformatf("end_of_vector exp %0b got %0b",
                                 want.end_of_vector, got.end_of_vector));
          end
        end
      end

      // a register write restarts the vector in progress
      if (cfg_we) begin
        window_reg = cfg_wdata;
        window_sum = '0;
        held_count = 0;
        wr_ptr     = '0;
      end

      if (in_valid && in_ready) begin
        win = active_window(window_reg);
        if (held_count >= win) begin
          oldest     = wr_ptr - 6'(win);
          window_sum = window_sum - 22'(sample_hist[oldest]);
        end else begin
          held_count++;
        end
        sample_hist[wr_ptr] = in_sample;
        window_sum          = window_sum + 22'(in_sample);
        wr_ptr              = wr_ptr + 6'd1;

        if (held_count >= win) begin
          scaled             = (longint'(window_sum) * 256) / longint'(win);
          want.average       = scaled[23:0];
          want.status        = AVG_VALID;
          want.end_of_vector = in_last;
          note_expected(want);
        end else if (in_last) begin
          want.average       = '0;
          want.status        = AVG_TOO_FEW;
          want.end_of_vector = 1'b1;
          note_expected(want);
        end

        if (in_last) begin
          window_sum = '0;
          held_count = 0;
          wr_ptr     = '0;
        end
      end
    end
    outstanding = expected_avgs.size();
  end

endmodule

// File: tb/sv/tb_windowed_moving_average_top.sv
`timescale 1ns / 100ps
// Top of the windowed moving average testbench: clock, reset, stimulus and verdict.
// Depends on wma_pkg, wma_if, windowed_moving_average_top and wma_average_checker.

module tb_windowed_moving_average_top
  import wma_pkg::*;
();

  localparam int WINDOW_MAX     = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_ITEMS   = 1300;

  typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_EXTREMES} fill_mode_e;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          samples_sent = 0;
  int          mismatches;
  int          outstanding;
  int unsigned quiet_cycles = 0;
  int unsigned cur_window = 1;

  wma_in_if  #(.SAMPLE_BITS(16)) in_ch ();
  wma_out_if #(.AVG_BITS(24))    out_ch ();

  windowed_moving_average_top #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(16)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  wma_average_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_sample  (in_ch.sample),
    .in_last    (in_ch.last_sample),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_average(out_ch.average),
    .out_status (out_ch.status),
    .out_eov    (out_ch.end_of_vector),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("windowed_moving_average_top: mismatch");
          $finish;
        end
      end
    end
  end

  task automatic push_sample(input logic signed [15:0] value, input logic last);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= value;
    in_ch.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    samples_sent++;
  endtask

  // hold off until every result is back and the pipeline has drained
  task automatic write_window(input logic [CFG_BITS-1:0] value);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (value == '0) cur_window = 1;
    else if (value > WINDOW_MAX) cur_window = WINDOW_MAX;
    else cur_window = 32'(value);
  endtask

  task automatic send_vector(input int len, input bit close, input fill_mode_e mode);
    logic signed [15:0] value;
    for (int i = 0; i < len; i++) begin
      case (mode)
        FILL_MAX:      value = 16'sh7fff;
        FILL_MIN:      value = 16'sh8000;
        FILL_EXTREMES: value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        default:       value = 16'($urandom());
      endcase
      push_sample(value, close && (i == len - 1));
    end
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input int goal);
    int         pick;
    int         nvec;
    int         len;
    bit         close;
    fill_mode_e mode;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    while (samples_sent < goal) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       write_window(7'd0);
        1:       write_window(7'd1);
        2:       write_window(7'd64);
        3:       write_window(7'd127);
        4, 5:    write_window(7'($urandom_range(2, 8)));
        default: write_window(7'($urandom_range(0, 127)));
      endcase
      nvec = $urandom_range(1, 4);
      for (int v = 0; v < nvec; v++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) len = $urandom_range(1, cur_window);
        else if (pick < 85) len = cur_window + $urandom_range(0, 24);
        else len = $urandom_range(1, 3);
        // leave the final vector open now and then so the next write cuts it off
        close = (v < nvec - 1) || ($urandom_range(0, 4) != 0);
        pick  = $urandom_range(0, 9);
        if (pick < 7) mode = FILL_RANDOM;
        else if (pick == 7) mode = FILL_MAX;
        else if (pick == 8) mode = FILL_MIN;
        else mode = FILL_EXTREMES;
        send_vector(len, close, mode);
      end
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.sample      = '0;
    in_ch.last_sample = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: window of one after reset
    snd_idle_pct = 19;
    rcv_idle_pct = 80;
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(16'shffff, 1'b1);

    // short vector, then full windows at the extremes
    write_window(7'd4);
    push_sample(16'sd100, 1'b0);
    push_sample(-16'sd5, 1'b1);
    repeat (4) push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh0001, 1'b1);

    // open vector restarted by a write of zero, which acts as one
    push_sample(16'sd7, 1'b0);
    push_sample(16'sd8, 1'b0);
    write_window(7'd0);
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sh7fff, 1'b1);

    // oversized window saturates, vector ends short
    write_window(7'd127);
    push_sample(16'sd1, 1'b0);
    push_sample(16'sd2, 1'b1);

    run_phase(19, 80, samples_sent + RANDOM_ITEMS / 3);
    run_phase(80, 19, samples_sent + RANDOM_ITEMS / 3);
    run_phase(0, 0, samples_sent + RANDOM_ITEMS / 3);

    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("windowed_moving_average_top: match");
    end else begin
      $display("windowed_moving_average_top: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/wma_pkg.sv
sv/wma_if.sv
sv/wma_ram.sv
sv/wma_front.sv
sv/wma_queue.sv
sv/wma_back.sv
sv/windowed_moving_average_top.sv
tb/sv/wma_average_checker.sv
tb/sv/tb_windowed_moving_average_top.sv
